// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sample mixer.
// Assertions sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSM_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define MSM_ASSERT(lbl, prop, msg)
`define MSM_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/msm_pkg.sv -----
// Types and constants for the multichannel sample mixer.
// No dependencies.
package msm_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned POS_BITS  = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam logic [6:0]  GAIN_MAX  = 7'd64;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_SETUP   = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_RESTART = 3'd3,
    REQ_RESUME  = 3'd4,
    REQ_TICK    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_REJECT   = 2'd1,
    STAT_DISABLED = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_SETTLE
  } state_e;

  typedef struct packed {
    logic en;
    logic loops;
    logic autod;
    logic oa;
    logic ob;
    logic data;
  } flags_t;

  // Voice command broadcast to the cells.
  typedef struct packed {
    logic        valid;
    req_e        op;
    logic [2:0]  voice;
    logic [15:0] base;
    logic [31:0] step;
    logic [31:0] len;
    logic [31:0] wrap;
    logic [6:0]  gain;
    logic        loops;
    logic        autod;
    logic        oa;
    logic        ob;
  } cmd_t;

  // Status a cell reports back to the controller.
  typedef struct packed {
    flags_t flags;
    logic   end_nz;
    logic   busy;
  } view_t;

endpackage

// ----- hw/rtl/msm_req_if.sv -----
// Request channel of the sample mixer: valid/ready plus request payload.
// Depends on nothing.
interface msm_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [2:0]        voice;
  logic [15:0]       address;
  logic signed [7:0] sample_byte;
  logic [31:0]       length;
  logic [31:0]       increment;
  logic [31:0]       wrap_length;
  logic [6:0]        volume;
  logic              loops;
  logic              auto_disable;
  logic              out_a;
  logic              out_b;

  modport source (
    output valid, req_type, voice, address, sample_byte, length, increment,
           wrap_length, volume, loops, auto_disable, out_a, out_b,
    input  ready
  );
  modport sink (
    input  valid, req_type, voice, address, sample_byte, length, increment,
           wrap_length, volume, loops, auto_disable, out_a, out_b,
    output ready
  );
endinterface

// ----- hw/rtl/msm_rsp_if.sv -----
// Response channel of the sample mixer: valid/ready plus result payload.
// Depends on nothing.
interface msm_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] mixed_sample;
  logic [1:0]        status;
  logic              sample_valid;

  modport source (output valid, mixed_sample, status, sample_valid, input ready);
  modport sink (input valid, mixed_sample, status, sample_valid, output ready);
endinterface

// ----- hw/rtl/multichannel_sample_mixer_top.sv -----
// Top level of the multichannel sample mixer.
// Depends on msm_pkg, msm_req_if, msm_rsp_if, msm_sample_ram, msm_voice_cell.
//
// Usage:
//   req_i (sink) takes one request per valid/ready handshake: load a sample
//   byte, set up / stop / restart / resume a voice, or a mix tick.
//   rsp_o (source) gives exactly one response per request, in order.
//   cfg_we_i/cfg_wdata_i write mix_enabled; write only while idle.
// Flow:
//   Loads, voice commands and ticks with mixing disabled answer in the next cycle.
//   A mix tick hands a token down the row of voice cells, one cell per
//   cycle; each cell reads RAM as the token arrives and adds its share in
//   the next cycle. A looping voice that overshoots its end by a loop
//   length or more runs a bit-serial remainder in its cell, and the tick
//   is answered only once every such remainder has finished.
//   One request is in flight at a time; the next is taken in the cycle the
//   previous response leaves the output register.
// Reset: voice flags cleared, mixing off, output register empty; RAM not reset.
// Stall: a held response keeps its value; no new request is taken until
//   the output register is free.
`include "assert_macros.svh"

module multichannel_sample_mixer_top #(
  parameter int unsigned VOICE_COUNT      = 8,
  parameter int unsigned SAMPLE_ADDR_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  msm_req_if.sink    req_i,
  msm_rsp_if.source  rsp_o
);

  msm_pkg::state_e state_q, state_d;
  logic            mix_en_q;
  logic            start_q;
  logic [15:0]     mix_sum_q;

  // output register
  logic              rsp_valid_q, rsp_valid_d;
  logic signed [7:0] rsp_mixed_q, rsp_mixed_d;
  msm_pkg::status_e  rsp_status_q, rsp_status_d;
  logic              rsp_sv_q, rsp_sv_d;
  logic              rsp_load;

  logic accept, rsp_free, voice_ok, setup_ok, busy_any;
  msm_pkg::req_e   req;
  msm_pkg::cmd_t   cmd;
  msm_pkg::view_t  sel_view;
  msm_pkg::view_t  views [VOICE_COUNT];
  logic [SAMPLE_ADDR_BITS-1:0] rd_addr;
  logic [SAMPLE_ADDR_BITS-1:0] cell_addr [VOICE_COUNT];
  logic [7:0]      rd_data;
  logic [VOICE_COUNT:0] tok_w;
  logic [15:0]     sum_w [VOICE_COUNT+1];

  assign req      = msm_pkg::req_e'(req_i.req_type);
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == msm_pkg::ST_IDLE) && rsp_free;
  assign accept   = req_i.valid && req_i.ready;
  assign voice_ok = (32'(req_i.voice) < VOICE_COUNT);
  assign setup_ok = (req_i.length != '0) && (req_i.increment != '0) &&
                    (req_i.loops == (req_i.wrap_length != '0)) &&
                    (req_i.wrap_length <= req_i.length);

  // Status of the addressed voice.
  always_comb begin
    sel_view = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (32'(req_i.voice) == i) sel_view = views[i];
    end
  end

  // Voice command broadcast.
  always_comb begin
    cmd       = '0;
    cmd.op    = req;
    cmd.voice = req_i.voice;
    cmd.base  = req_i.address;
    cmd.step  = req_i.increment;
    cmd.len   = req_i.length;
    cmd.wrap  = req_i.wrap_length;
    cmd.gain  = (req_i.volume > msm_pkg::GAIN_MAX) ? msm_pkg::GAIN_MAX : req_i.volume;
    cmd.loops = req_i.loops;
    cmd.autod = req_i.auto_disable;
    cmd.oa    = req_i.out_a;
    cmd.ob    = req_i.out_b;
    case (req)
      msm_pkg::REQ_SETUP: cmd.valid = accept && voice_ok && setup_ok;
      msm_pkg::REQ_STOP, msm_pkg::REQ_RESTART, msm_pkg::REQ_RESUME:
        cmd.valid = accept && voice_ok;
      default: cmd.valid = 1'b0;
    endcase
  end

  msm_sample_ram #(.ADDR_BITS(SAMPLE_ADDR_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (req == msm_pkg::REQ_LOAD)),
    .waddr_i (SAMPLE_ADDR_BITS'(req_i.address)),
    .wdata_i (req_i.sample_byte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign tok_w[0] = start_q;
  assign sum_w[0] = '0;

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
    msm_voice_cell #(.INDEX(g), .ADDR_BITS(SAMPLE_ADDR_BITS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .tok_i     (tok_w[g]),
      .sum_i     (sum_w[g]),
      .rd_data_i (rd_data),
      .rd_addr_o (cell_addr[g]),
      .tok_o     (tok_w[g+1]),
      .sum_o     (sum_w[g+1]),
      .view_o    (views[g])
    );
  end

  // Only the cell holding the token drives a nonzero address.
  always_comb begin
    rd_addr  = '0;
    busy_any = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      rd_addr  = rd_addr | cell_addr[i];
      busy_any = busy_any | views[i].busy;
    end
  end

  always_comb begin
    state_d      = state_q;
    rsp_load     = 1'b0;
    rsp_mixed_d  = '0;
    rsp_status_d = msm_pkg::STAT_DONE;
    rsp_sv_d     = 1'b0;
    case (state_q)
      msm_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (req)
            msm_pkg::REQ_LOAD: ;
            msm_pkg::REQ_SETUP: begin
              if (!voice_ok || !setup_ok) rsp_status_d = msm_pkg::STAT_REJECT;
            end
            msm_pkg::REQ_STOP: begin
              if (!voice_ok) rsp_status_d = msm_pkg::STAT_REJECT;
            end
            msm_pkg::REQ_RESTART: begin
              if (!voice_ok) begin
                rsp_status_d = msm_pkg::STAT_REJECT;
              end else if (!sel_view.flags.data || !sel_view.end_nz ||
                           !(sel_view.flags.oa || sel_view.flags.ob)) begin
                rsp_status_d = msm_pkg::STAT_IGNORED;
              end
            end
            msm_pkg::REQ_RESUME: begin
              if (!voice_ok) begin
                rsp_status_d = msm_pkg::STAT_REJECT;
              end else if (!sel_view.flags.data || !sel_view.end_nz ||
                           sel_view.flags.en) begin
                rsp_status_d = msm_pkg::STAT_IGNORED;
              end
            end
            msm_pkg::REQ_TICK: begin
              if (!mix_en_q) begin
                rsp_status_d = msm_pkg::STAT_DISABLED;
              end else begin
                rsp_load = 1'b0;
                state_d  = msm_pkg::ST_CHAIN;
              end
            end
            default: rsp_status_d = msm_pkg::STAT_IGNORED;
          endcase
        end
      end
      msm_pkg::ST_CHAIN: begin
        if (tok_w[VOICE_COUNT]) state_d = msm_pkg::ST_SETTLE;
      end
      msm_pkg::ST_SETTLE: begin
        // wait for wrap remainders still running in the cells and a free output register
        if (!busy_any && rsp_free) begin
          rsp_load    = 1'b1;
          rsp_mixed_d = mix_sum_q[15:8];
          rsp_sv_d    = 1'b1;
          state_d     = msm_pkg::ST_IDLE;
        end
      end
      default: state_d = msm_pkg::ST_IDLE;
    endcase
    rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msm_pkg::ST_IDLE;
      mix_en_q    <= 1'b0;
      start_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept && (req == msm_pkg::REQ_TICK) && mix_en_q;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) mix_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_mixed_q  <= rsp_mixed_d;
      rsp_status_q <= rsp_status_d;
      rsp_sv_q     <= rsp_sv_d;
    end
    if (tok_w[VOICE_COUNT]) mix_sum_q <= sum_w[VOICE_COUNT];
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.mixed_sample = rsp_mixed_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.sample_valid = rsp_sv_q;

  `MSM_ASSERT(a_one_token, $onehot0(tok_w), "more than one token in the voice chain")
  `MSM_ASSERT_NEVER(a_tok_state, (|tok_w[VOICE_COUNT-1:0]) && (state_q != msm_pkg::ST_CHAIN), "token outside a mix tick")
  `MSM_ASSERT(a_sample_done, (rsp_valid_q && rsp_sv_q) |-> (rsp_status_q == msm_pkg::STAT_DONE), "mixed sample with nonzero status")
  `MSM_ASSERT(a_settle_idle, (state_q == msm_pkg::ST_SETTLE && rsp_load) |=> (state_q == msm_pkg::ST_IDLE && !busy_any), "tick answered while a voice still advances")

endmodule

// ----- hw/rtl/msm_sample_ram.sv -----
// Signed 8-bit sample memory, one write and one registered read port.
// No package dependencies.
module msm_sample_ram #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/msm_voice_cell.sv -----
// One voice of the mixer: voice state, its share of the mix and its advance.
// Depends on msm_pkg. A token with the running sum walks through the cells.
module msm_voice_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msm_pkg::cmd_t        cmd_i,
  input  logic                 tok_i,
  input  logic [15:0]          sum_i,
  input  logic [7:0]           rd_data_i,
  output logic [ADDR_BITS-1:0] rd_addr_o,
  output logic                 tok_o,
  output logic [15:0]          sum_o,
  output msm_pkg::view_t       view_o
);

  logic [15:0]     base_q, base_d;
  logic [31:0]     pos_q, pos_d, step_q, step_d, end_q, end_d, wrap_q, wrap_d;
  logic [6:0]      gain_q, gain_d;
  msm_pkg::flags_t flags_q, flags_d;
  logic            ph1_q, act_q, act_d;
  logic [15:0]     sum_q;
  logic            div_busy_q, div_busy_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [31:0]     rem_q, rem_d, dvd_q, dvd_d;

  logic              hit, active;
  logic [31:0]       p_adv, d_adv;
  logic [32:0]       cand, cand_sub;
  logic signed [15:0] prod;
  logic [ADDR_BITS-1:0] addr;

  assign hit = cmd_i.valid && (32'(cmd_i.voice) == INDEX);

  assign active = flags_q.data && flags_q.oa && flags_q.en &&
                  !(!flags_q.loops && !flags_q.autod && (pos_q >= end_q));

  assign addr = ADDR_BITS'(ADDR_BITS'(base_q) +
                ADDR_BITS'(pos_q[msm_pkg::POS_BITS-1:msm_pkg::FRAC_BITS]));
  assign rd_addr_o = tok_i ? addr : '0;

  assign prod  = $signed(rd_data_i) * $signed({1'b0, gain_q});
  assign tok_o = ph1_q;
  assign sum_o = sum_q + (act_q ? prod : 16'sd0);

  assign p_adv    = pos_q + step_q;
  assign d_adv    = p_adv - end_q;
  assign cand     = {rem_q, dvd_q[31]};
  assign cand_sub = cand - {1'b0, wrap_q};

  assign view_o.flags  = flags_q;
  assign view_o.end_nz = (end_q != '0);
  assign view_o.busy   = div_busy_q;

  always_comb begin
    base_d     = base_q;
    pos_d      = pos_q;
    step_d     = step_q;
    end_d      = end_q;
    wrap_d     = wrap_q;
    gain_d     = gain_q;
    flags_d    = flags_q;
    act_d      = tok_i ? active : 1'b0;
    div_busy_d = div_busy_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;

    if (hit) begin
      case (cmd_i.op)
        msm_pkg::REQ_SETUP: begin
          base_d        = cmd_i.base;
          pos_d         = '0;
          step_d        = cmd_i.step;
          end_d         = cmd_i.len;
          wrap_d        = cmd_i.wrap;
          gain_d        = cmd_i.gain;
          flags_d.en    = 1'b1;
          flags_d.data  = 1'b1;
          flags_d.loops = cmd_i.loops;
          flags_d.autod = cmd_i.autod;
          flags_d.oa    = cmd_i.oa;
          flags_d.ob    = cmd_i.ob;
        end
        msm_pkg::REQ_STOP: flags_d.en = 1'b0;
        msm_pkg::REQ_RESTART: begin
          if (flags_q.data && (end_q != '0) && (flags_q.oa || flags_q.ob)) begin
            pos_d      = '0;
            flags_d.en = 1'b1;
          end
        end
        msm_pkg::REQ_RESUME: begin
          if (flags_q.data && (end_q != '0) && !flags_q.en) begin
            flags_d.en = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Advance after this voice's share went into the sum.
    if (ph1_q && act_q) begin
      if (p_adv >= end_q) begin
        if (flags_q.loops && (wrap_q != '0)) begin
          if (d_adv < wrap_q) begin
            pos_d = p_adv - wrap_q;
          end else begin
            div_busy_d = 1'b1;
            cnt_d      = '0;
            rem_d      = '0;
            dvd_d      = d_adv;
          end
        end else begin
          pos_d = p_adv;
        end
        if (flags_q.autod) begin
          flags_d.en = 1'b0;
        end
      end else begin
        pos_d = p_adv;
      end
    end

    // Restoring remainder of the overshoot by the loop length.
    if (div_busy_q) begin
      if (cnt_q != 6'(msm_pkg::DIV_STEPS)) begin
        rem_d = cand_sub[32] ? cand[31:0] : cand_sub[31:0];
        dvd_d = {dvd_q[30:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
      end else begin
        pos_d      = end_q + rem_q - wrap_q;
        div_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      ph1_q      <= 1'b0;
      act_q      <= 1'b0;
      div_busy_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      flags_q    <= flags_d;
      ph1_q      <= tok_i;
      act_q      <= act_d;
      div_busy_q <= div_busy_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    end_q  <= end_d;
    wrap_q <= wrap_d;
    gain_q <= gain_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    if (tok_i) begin
      sum_q <= sum_i;
    end
  end

endmodule

// ----- dv/multichannel_sample_mixer_top_tb.sv -----
// Self-checking testbench for multichannel_sample_mixer_top.
// Depends on msm_pkg, msm_req_if, msm_rsp_if and the mixer RTL; an in-bench
// model of the voices and sample RAM predicts each response.
`timescale 1ns / 100ps

module multichannel_sample_mixer_top_tb;

  // Request codes outside the defined set; the mixer must ignore them.
  localparam logic [2:0] REQ_UNDEF_A = 3'd6;
  localparam logic [2:0] REQ_UNDEF_B = 3'd7;
  localparam int unsigned N_VOICE = 8;
  localparam int unsigned SETTLE_CYC = 2 * N_VOICE + 60;

  typedef struct {
    logic [2:0]        kind;
    logic [2:0]        voice;
    logic [15:0]       addr;
    logic signed [7:0] sbyte;
    logic [31:0]       len;
    logic [31:0]       inc;
    logic [31:0]       wrap;
    logic [6:0]        vol;
    logic              loops;
    logic              autod;
    logic              oa;
    logic              ob;
  } mix_req_t;

  typedef struct {
    logic signed [7:0] mixed;
    logic [1:0]        status;
    logic              svalid;
  } mix_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  msm_req_if req_if ();
  msm_rsp_if rsp_if ();

  multichannel_sample_mixer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Model state: sample RAM with a written mask, voice registers, mix enable.
  // ---------------------------------------------------------------------------
  logic signed [7:0] ram_q [65536];
  bit                ram_loaded [65536];
  logic [15:0]       v_base [N_VOICE];
  logic [31:0]       v_pos [N_VOICE];
  logic [31:0]       v_step [N_VOICE];
  logic [31:0]       v_end [N_VOICE];
  logic [31:0]       v_wrap [N_VOICE];
  logic [6:0]        v_gain [N_VOICE];
  msm_pkg::flags_t   v_flags [N_VOICE];
  logic              mix_en;

  mix_rsp_t rsp_expect_q [$];
  int unsigned mismatches;
  bit  calm;          // no idling on either side while set
  int  hold_cycles;   // receiver hold-off, counted down by the ready driver

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // A voice reads RAM on this tick only if enabled, routed to A and not
  // parked past its end.
  function automatic bit voice_reads(int v);
    msm_pkg::flags_t f;
    f = v_flags[v];
    if (!f.data || !f.oa || !f.en) return 1'b0;
    if (!(f.loops || f.autod) && v_pos[v] >= v_end[v]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] voice_addr(int v);
    return 16'(v_base[v] + v_pos[v][31:12]);
  endfunction

  // Contribution of one voice (low 16 bits of sample*gain), then advance.
  function automatic logic [15:0] voice_advance(int v);
    logic [31:0] p;
    int s;
    int g;
    int prod;
    longint unsigned k;
    if (!voice_reads(v)) return 16'd0;
    s = ram_q[voice_addr(v)];
    g = v_gain[v];
    prod = s * g;
    p = v_pos[v] + v_step[v];
    if (p >= v_end[v]) begin
      if (v_flags[v].loops && v_wrap[v] != 0) begin
        k = longint'((p - v_end[v]) / v_wrap[v]) + 1;
        p = p - 32'(k * longint'(v_wrap[v]));
      end
      if (v_flags[v].autod) v_flags[v].en = 1'b0;
    end
    v_pos[v] = p;
    return prod[15:0];
  endfunction

  function automatic mix_rsp_t mix_predict(mix_req_t r);
    mix_rsp_t e;
    logic [15:0] sum;
    int v;
    e.mixed = '0;
    e.status = msm_pkg::STAT_DONE;
    e.svalid = 1'b0;
    v = r.voice;
    case (r.kind)
      msm_pkg::REQ_LOAD: begin
        ram_q[r.addr] = r.sbyte;
        ram_loaded[r.addr] = 1'b1;
      end
      msm_pkg::REQ_SETUP: begin
        if (r.len == 0 || r.inc == 0 || (r.loops != (r.wrap != 0)) || r.wrap > r.len) begin
          e.status = msm_pkg::STAT_REJECT;
        end else begin
          v_base[v] = r.addr;
          v_pos[v] = '0;
          v_step[v] = r.inc;
          v_end[v] = r.len;
          v_wrap[v] = r.wrap;
          v_gain[v] = (r.vol > msm_pkg::GAIN_MAX) ? msm_pkg::GAIN_MAX : r.vol;
          v_flags[v] = '{en: 1'b1, loops: r.loops, autod: r.autod, oa: r.oa, ob: r.ob,
                         data: 1'b1};
        end
      end
      msm_pkg::REQ_STOP: v_flags[v].en = 1'b0;
      msm_pkg::REQ_RESTART: begin
        if (!v_flags[v].data || v_end[v] == 0 || !(v_flags[v].oa || v_flags[v].ob)) begin
          e.status = msm_pkg::STAT_IGNORED;
        end else begin
          v_pos[v] = '0;
          v_flags[v].en = 1'b1;
        end
      end
      msm_pkg::REQ_RESUME: begin
        if (!v_flags[v].data || v_end[v] == 0 || v_flags[v].en)
          e.status = msm_pkg::STAT_IGNORED;
        else v_flags[v].en = 1'b1;
      end
      msm_pkg::REQ_TICK: begin
        if (!mix_en) begin
          e.status = msm_pkg::STAT_DISABLED;
        end else begin
          sum = '0;
          for (int i = 0; i < N_VOICE; i++) sum = sum + voice_advance(i);
          e.mixed = sum[15:8];
          e.svalid = 1'b1;
        end
      end
      default: e.status = msm_pkg::STAT_IGNORED;
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one request per call, with random gaps unless calm.
  // Called right after a rising edge; returns at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(mix_req_t r);
    int gap;
    rsp_expect_q.push_back(mix_predict(r));
    if (!calm && $urandom_range(99) < 17) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.kind;
    req_if.voice        <= r.voice;
    req_if.address      <= r.addr;
    req_if.sample_byte  <= r.sbyte;
    req_if.length       <= r.len;
    req_if.increment    <= r.inc;
    req_if.wrap_length  <= r.wrap;
    req_if.volume       <= r.vol;
    req_if.loops        <= r.loops;
    req_if.auto_disable <= r.autod;
    req_if.out_a        <= r.oa;
    req_if.out_b        <= r.ob;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic mix_req_t blank_req(logic [2:0] kind, logic [2:0] voice);
    mix_req_t r;
    r = '{kind: kind, voice: voice, addr: 16'($urandom), sbyte: 8'($urandom),
          len: $urandom, inc: $urandom, wrap: $urandom, vol: 7'($urandom),
          loops: 1'($urandom), autod: 1'($urandom), oa: 1'($urandom),
          ob: 1'($urandom)};
    return r;
  endfunction

  task automatic load_byte(logic [15:0] a, logic signed [7:0] b);
    mix_req_t r;
    r = blank_req(msm_pkg::REQ_LOAD, 3'($urandom));
    r.addr = a;
    r.sbyte = b;
    send_request(r);
  endtask

  task automatic setup_voice(logic [2:0] v, logic [15:0] base, logic [31:0] len,
                             logic [31:0] inc, logic [31:0] wrap, logic [6:0] vol,
                             logic loops, logic autod, logic oa, logic ob);
    mix_req_t r;
    r = blank_req(msm_pkg::REQ_SETUP, v);
    r.addr = base; r.len = len; r.inc = inc; r.wrap = wrap; r.vol = vol;
    r.loops = loops; r.autod = autod; r.oa = oa; r.ob = ob;
    send_request(r);
  endtask

  // A tick must never read an unloaded byte: load any the voices would touch.
  task automatic mix_tick();
    logic [15:0] a;
    if (mix_en) begin
      for (int v = 0; v < N_VOICE; v++) begin
        if (voice_reads(v)) begin
          a = voice_addr(v);
          if (!ram_loaded[a]) load_byte(a, 8'($urandom));
        end
      end
    end
    send_request(blank_req(msm_pkg::REQ_TICK, 3'($urandom)));
  endtask

  // Wait until every response is back and the block has gone quiet.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_mix_enable(logic val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mix_en = val;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready driver and checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    mix_rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
      end else begin
        e = rsp_expect_q.pop_front();
        if (rsp_if.mixed_sample !== e.mixed || rsp_if.status !== e.status ||
            rsp_if.sample_valid !== e.svalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp mixed %0d status %0d valid %0b, got %0d %0d %0b",
                     $realtime, e.mixed, e.status, e.svalid, rsp_if.mixed_sample,
                     rsp_if.status, rsp_if.sample_valid);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh voices: ticks disabled, stop always done, restart/resume ignored,
  // undefined request codes ignored.
  task automatic test_after_reset();
    mix_tick();
    send_request(blank_req(msm_pkg::REQ_STOP, 3'd0));
    send_request(blank_req(msm_pkg::REQ_RESTART, 3'd7));
    send_request(blank_req(msm_pkg::REQ_RESUME, 3'd3));
    send_request(blank_req(REQ_UNDEF_A, 3'd1));
    send_request(blank_req(REQ_UNDEF_B, 3'd2));
  endtask

  // Each rejection rule, then extreme but legal setups.
  task automatic test_setup_rules();
    setup_voice(3'd0, 16'h0000, 32'd0, 32'h1000, 32'd0, 7'd10, 1'b0, 1'b0, 1'b1, 1'b0);
    setup_voice(3'd0, 16'h0000, 32'h4000, 32'd0, 32'd0, 7'd10, 1'b0, 1'b0, 1'b1, 1'b0);
    setup_voice(3'd0, 16'h0000, 32'h4000, 32'h1000, 32'h1000, 7'd10, 1'b0, 1'b0, 1'b1, 1'b0);
    setup_voice(3'd0, 16'h0000, 32'h4000, 32'h1000, 32'd0, 7'd10, 1'b1, 1'b0, 1'b1, 1'b0);
    setup_voice(3'd0, 16'h0000, 32'h4000, 32'h1000, 32'h5000, 7'd10, 1'b1, 1'b0, 1'b1, 1'b0);
    load_byte(16'hFFFF, 8'sh7F);
    load_byte(16'h0000, -8'sd128);
    load_byte(16'h0001, 8'sh01);
    // volume clamp, base wrap to address zero, loop at full length
    setup_voice(3'd0, 16'hFFFF, 32'h3000, 32'h1000, 32'h3000, 7'd127, 1'b1, 1'b0, 1'b1, 1'b0);
    setup_voice(3'd1, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 7'd64, 1'b0, 1'b0,
                1'b1, 1'b1);
    setup_voice(3'd2, 16'h0001, 32'h1000, 32'h0000_0001, 32'd0, 7'd0, 1'b0, 1'b1, 1'b1, 1'b0);
    // only on B: silent in the mix, still restartable
    setup_voice(3'd3, 16'h0000, 32'h2000, 32'h0800, 32'd0, 7'd33, 1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  // Ticks over the directed voices: past-end hold, auto-disable, loop wrap.
  task automatic test_directed_mix();
    write_mix_enable(1'b1);
    repeat (4) mix_tick();
    send_request(blank_req(msm_pkg::REQ_RESUME, 3'd1));
    send_request(blank_req(msm_pkg::REQ_STOP, 3'd1));
    send_request(blank_req(msm_pkg::REQ_RESUME, 3'd1));
    send_request(blank_req(msm_pkg::REQ_RESTART, 3'd3));
    // step far beyond a short loop: multi-wrap remainder path
    setup_voice(3'd4, 16'h0000, 32'h2000, 32'h00F0_0000, 32'h0100, 7'd64, 1'b1, 1'b1,
                1'b1, 1'b0);
    repeat (3) mix_tick();
    write_mix_enable(1'b0);
    mix_tick();
  endtask

  task automatic random_setup(output mix_req_t r);
    r = blank_req(msm_pkg::REQ_SETUP, 3'($urandom));
    if ($urandom_range(99) < 85) begin
      r.addr  = 16'($urandom_range(0, 255));
      r.len   = ($urandom_range(1, 48) << 12) + $urandom_range(0, 4095);
      r.inc   = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(1, 16'h3000));
      r.wrap  = r.loops ? 32'($urandom_range(1, r.len)) : 32'd0;
      if ($urandom_range(9) == 0 && r.loops) r.wrap = $urandom_range(1, 64);
    end
  endtask

  task automatic test_random(int unsigned n_items);
    mix_req_t r;
    int unsigned pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      calm = (i >= n_items / 3) && (i < n_items / 3 + 150);
      if (i % 300 == 299) write_mix_enable(~mix_en);
      pick = $urandom_range(99);
      if (pick < 36) begin
        mix_tick();
      end else if (pick < 60) begin
        random_setup(r);
        send_request(r);
      end else if (pick < 75) begin
        r = blank_req(msm_pkg::REQ_LOAD, 3'($urandom));
        if ($urandom_range(3) != 0) r.addr = 16'($urandom_range(0, 300));
        send_request(r);
      end else if (pick < 81) begin
        send_request(blank_req(msm_pkg::REQ_STOP, 3'($urandom)));
      end else if (pick < 88) begin
        send_request(blank_req(msm_pkg::REQ_RESTART, 3'($urandom)));
      end else if (pick < 96) begin
        send_request(blank_req(msm_pkg::REQ_RESUME, 3'($urandom)));
      end else begin
        send_request(blank_req(($urandom_range(1) != 0) ? REQ_UNDEF_A : REQ_UNDEF_B,
                               3'($urandom)));
      end
    end
    calm = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    settle();
    write_mix_enable(1'b1);
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) mix_tick();
      else send_request(blank_req(msm_pkg::REQ_RESUME, 3'($urandom)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = msm_pkg::REQ_LOAD;
    req_if.voice = '0;
    req_if.address = '0;
    req_if.sample_byte = '0;
    req_if.length = '0;
    req_if.increment = '0;
    req_if.wrap_length = '0;
    req_if.volume = '0;
    req_if.loops = 1'b0;
    req_if.auto_disable = 1'b0;
    req_if.out_a = 1'b0;
    req_if.out_b = 1'b0;
    rsp_if.ready = 1'b0;
    mismatches = 0;
    calm = 1'b0;
    hold_cycles = 0;
    mix_en = 1'b0;
    for (int v = 0; v < N_VOICE; v++) begin
      v_base[v] = '0; v_pos[v] = '0; v_step[v] = '0; v_end[v] = '0;
      v_wrap[v] = '0; v_gain[v] = '0; v_flags[v] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_setup_rules();
    test_directed_mix();
    write_mix_enable(1'b1);
    test_random(1250);
    test_backpressure();
    settle();

    if (mismatches == 0 && rsp_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/msm_pkg.sv
hw/rtl/msm_req_if.sv
hw/rtl/msm_rsp_if.sv
hw/rtl/msm_sample_ram.sv
hw/rtl/msm_voice_cell.sv
hw/rtl/multichannel_sample_mixer_top.sv
dv/multichannel_sample_mixer_top_tb.sv
